@@ sv/hlb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hlb_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LOW_A = 8'h61;
  localparam logic [7:0] CHAR_LOW_F = 8'h66;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_UP_F  = 8'h46;
  localparam logic [7:0] CHAR_LOW_X = 8'h78;

  localparam logic [1:0] DIGITS_SAT = 2'd3;

  typedef struct packed {
    logic [7:0] in_char;
    logic       is_end;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       overflow_warning;
    logic       last_of_run;
  } out_t;

  // results produced by one item: count, then first and second beat
  typedef struct packed {
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } scan_res_t;

  // returns {is digit, digit value}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] t;
    t = 8'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      t = c - CHAR_ZERO;
      return {1'b1, t[3:0]};
    end
    if (c >= CHAR_LOW_A && c <= CHAR_LOW_F) begin
      t = c - CHAR_LOW_A + 8'd10;
      return {1'b1, t[3:0]};
    end
    if (c >= CHAR_UP_A && c <= CHAR_UP_F) begin
      t = c - CHAR_UP_A + 8'd10;
      return {1'b1, t[3:0]};
    end
    return 5'd0;
  endfunction

endpackage

`default_nettype wire

@@ sv/hex_literal_to_bytes_unit.sv @@
// channel | direction | beat type | handshake
// in      | input     | in_t      | in_valid_i / in_stall_o
// out     | output    | out_t     | out_valid_o / out_stall_i
//
// one character per cycle unless stalled; the input register feeds the queue
// a non-overflowing token of three or more digits gives two beats from a
// four-entry result queue, so the queue's drain rate sets the sustained figure
// input stalls only while the input register holds a beat and fewer than two
// queue entries are free
// reset clears the scan state and empties the queue at once
`timescale 1ns / 1ps
`default_nettype none

module hex_literal_to_bytes_unit import hlb_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output out_t      out_data_o
);

  logic        in_full_q, in_full_d;
  in_t         in_data_q;
  logic        accept_in, adv, pop;
  scan_res_t   res;

  out_t        queue_q [4];
  logic [1:0]  wptr_q, wptr_d;
  logic [1:0]  rptr_q, rptr_d;
  logic [2:0]  fill_q, fill_d;

  assign adv        = (fill_q <= 3'd2);
  assign in_stall_o = in_full_q & ~adv;
  assign accept_in  = in_valid_i & ~in_stall_o;
  assign in_full_d  = accept_in | (in_full_q & ~adv);

  hlb_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_full_q & adv),
    .item_i (in_data_q),
    .res_o  (res)
  );

  assign out_valid_o = (fill_q != 3'd0);
  assign out_data_o  = queue_q[rptr_q];
  assign pop         = out_valid_o & ~out_stall_i;

  assign wptr_d = wptr_q + res.n;
  assign rptr_d = rptr_q + {1'b0, pop};
  assign fill_d = fill_q + {1'b0, res.n} - {2'b00, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
      wptr_q    <= 2'd0;
      rptr_q    <= 2'd0;
      fill_q    <= 3'd0;
    end else begin
      in_full_q <= in_full_d;
      wptr_q    <= wptr_d;
      rptr_q    <= rptr_d;
      fill_q    <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) in_data_q <= in_data_i;
    if (res.n != 2'd0) queue_q[wptr_q] <= res.r0;
    if (res.n == 2'd2) queue_q[wptr_q + 2'd1] <= res.r1;
  end

endmodule

`default_nettype wire

@@ sv/hlb_scan.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hlb_scan import hlb_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      fire_i,
  input  wire in_t       item_i,
  output scan_res_t      res_o
);

  logic        in_tok_q, in_tok_d;
  logic        prev_zero_q, prev_zero_d;
  logic [15:0] value_q, value_d;
  logic [1:0]  count_q, count_d;
  logic        ovf_q, ovf_d;

  logic [4:0]  dig;
  logic        is_zero, is_x;
  scan_res_t   emit;

  assign dig     = hex_digit(item_i.in_char);
  assign is_zero = (item_i.in_char == CHAR_ZERO);
  assign is_x    = (item_i.in_char == CHAR_LOW_X);

  // what the pending token gives when it closes
  always_comb begin
    emit.r1 = '{out_byte: value_q[7:0], overflow_warning: 1'b0, last_of_run: 1'b1};
    if (ovf_q) begin
      emit.n  = 2'd1;
      emit.r0 = '{out_byte: 8'd0, overflow_warning: 1'b1, last_of_run: 1'b1};
    end else if (count_q == DIGITS_SAT) begin
      emit.n  = 2'd2;
      emit.r0 = '{out_byte: value_q[15:8], overflow_warning: 1'b0, last_of_run: 1'b0};
    end else begin
      emit.n  = 2'd1;
      emit.r0 = '{out_byte: value_q[7:0], overflow_warning: 1'b0, last_of_run: 1'b1};
    end
  end

  always_comb begin
    in_tok_d    = in_tok_q;
    prev_zero_d = prev_zero_q;
    value_d     = value_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    res_o       = emit;
    res_o.n     = 2'd0;

    if (item_i.is_end) begin
      if (in_tok_q) res_o.n = emit.n;
      in_tok_d    = 1'b0;
      prev_zero_d = 1'b0;
      value_d     = 16'd0;
      count_d     = 2'd0;
      ovf_d       = 1'b0;
    end else if (!in_tok_q) begin
      if (prev_zero_q && is_x) begin
        in_tok_d    = 1'b1;
        prev_zero_d = 1'b0;
        value_d     = 16'd0;
        count_d     = 2'd0;
        ovf_d       = 1'b0;
      end else begin
        prev_zero_d = is_zero;
      end
    end else if (dig[4]) begin
      // shifting in a nibble overflows iff the top nibble is already set
      if (!ovf_q) begin
        if (value_q[15:12] != 4'd0) ovf_d = 1'b1;
        else value_d = {value_q[11:0], dig[3:0]};
      end
      if (count_q != DIGITS_SAT) count_d = count_q + 2'd1;
      prev_zero_d = is_zero;
    end else begin
      res_o.n = emit.n;
      if (is_x && prev_zero_q) begin
        in_tok_d    = 1'b1;
        value_d     = 16'd0;
        count_d     = 2'd0;
        ovf_d       = 1'b0;
      end else begin
        in_tok_d    = 1'b0;
      end
      prev_zero_d = 1'b0;
    end
    if (!fire_i) res_o.n = 2'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_tok_q    <= 1'b0;
      prev_zero_q <= 1'b0;
      value_q     <= 16'd0;
      count_q     <= 2'd0;
      ovf_q       <= 1'b0;
    end else if (fire_i) begin
      in_tok_q    <= in_tok_d;
      prev_zero_q <= prev_zero_d;
      value_q     <= value_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/hlb_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module hlb_checker import hlb_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire in_t  in_data_i,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire out_t out_data_o
);

  // a stalled input beat holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input beat changed");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // a warning carries a zero byte and closes its run
  a_warn_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow_warning |->
      out_data_o.out_byte == 8'd0 && out_data_o.last_of_run)
    else $error("malformed warning beat");

  // high byte is never a warning
  a_first_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |-> !out_data_o.overflow_warning)
    else $error("warning on a non-final beat");

  // the low byte is already queued behind the high byte
  a_pair_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_of_run |=> out_valid_o)
    else $error("byte pair split by a gap");

endmodule

bind hex_literal_to_bytes_unit hlb_checker u_hlb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
